/* rtl/fss_pkg.sv */
package fss_pkg;

    localparam int REPLY_BUFFER_BYTES = 64;
    localparam int HEAD_KEEP          = 14;
    localparam int ACK_MIN_BYTES      = 12;
    localparam int CNT_W              = $clog2(REPLY_BUFFER_BYTES + 1);

    localparam logic [7:0] SOF_HI     = 8'hEF;
    localparam logic [7:0] SOF_LO     = 8'h01;
    localparam logic [7:0] PID_CMD    = 8'h01;
    localparam logic [7:0] PID_ACK    = 8'h07;
    localparam logic [7:0] CC_OK      = 8'h00;
    localparam logic [7:0] CC_NOFING  = 8'h02;
    localparam logic [7:0] CC_NOACK   = 8'hFF;
    localparam logic [7:0] INS_CAP    = 8'h01;
    localparam logic [7:0] INS_CONV   = 8'h02;
    localparam logic [7:0] INS_SEARCH = 8'h1B;
    localparam logic [7:0] BUF_ID     = 8'h01;

    localparam logic [2:0] REG_CAP_TO    = 3'd0;
    localparam logic [2:0] REG_PREDELAY  = 3'd1;
    localparam logic [2:0] REG_CONV_TO   = 3'd2;
    localparam logic [2:0] REG_SEARCH_TO = 3'd3;
    localparam logic [2:0] REG_START_PG  = 3'd4;
    localparam logic [2:0] REG_PAGE_CNT  = 3'd5;
    localparam logic [2:0] REG_ADDR      = 3'd6;

    localparam logic [1:0] ST_MATCH   = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_START = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_CAPTURE,
        PH_PREDELAY,
        PH_WAIT_CONVERT,
        PH_WAIT_SEARCH
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CAPTURE,
        ACT_CONVERT,
        ACT_SEARCH,
        ACT_STATUS
    } t_act;

    typedef struct packed {
        t_act        act;
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] score;
    } t_act_req;

endpackage

/* rtl/fss_emit.sv */
module fss_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  fss_pkg::t_act_req i_req,
    output logic            o_req_ready,
    input  logic [31:0]     i_dev_addr,
    input  logic [15:0]     i_start_page,
    input  logic [15:0]     i_page_count,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [7:0]      o_tx_byte,
    output logic            o_last,
    output logic [1:0]      o_status,
    output logic [15:0]     o_id,
    output logic [15:0]     o_score
);
    import fss_pkg::*;

    logic        r_busy;
    t_act_req    r_req;
    logic [4:0]  r_idx;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_tx;
    logic        r_last;
    logic [1:0]  r_status;
    logic [15:0] r_id;
    logic [15:0] r_score;

    logic        advance;
    logic        load;
    logic [7:0]  fb;
    logic        flast;
    logic [15:0] search_sum;

    assign advance     = !r_valid || i_ready;
    assign load        = r_busy && advance;
    assign o_req_ready = !r_busy;

    assign search_sum = 16'h0001 + 16'h0008 + {8'h00, INS_SEARCH} + {8'h00, BUF_ID}
                      + {8'h00, i_start_page[15:8]} + {8'h00, i_start_page[7:0]}
                      + {8'h00, i_page_count[15:8]} + {8'h00, i_page_count[7:0]};

    always_comb begin
        fb    = 8'h00;
        flast = 1'b0;
        unique case (r_idx)
            5'd0: fb = SOF_HI;
            5'd1: fb = SOF_LO;
            5'd2: fb = i_dev_addr[31:24];
            5'd3: fb = i_dev_addr[23:16];
            5'd4: fb = i_dev_addr[15:8];
            5'd5: fb = i_dev_addr[7:0];
            5'd6: fb = PID_CMD;
            5'd7: fb = 8'h00;
            default: begin
                unique case (r_req.act)
                    ACT_CAPTURE: begin
                        unique case (r_idx)
                            5'd8:  fb = 8'h03;
                            5'd9:  fb = INS_CAP;
                            5'd10: fb = 8'h00;
                            default: begin
                                fb    = 8'h05;
                                flast = 1'b1;
                            end
                        endcase
                    end
                    ACT_CONVERT: begin
                        unique case (r_idx)
                            5'd8:  fb = 8'h04;
                            5'd9:  fb = INS_CONV;
                            5'd10: fb = BUF_ID;
                            5'd11: fb = 8'h00;
                            default: begin
                                fb    = 8'h08;
                                flast = 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        unique case (r_idx)
                            5'd8:  fb = 8'h08;
                            5'd9:  fb = INS_SEARCH;
                            5'd10: fb = BUF_ID;
                            5'd11: fb = i_start_page[15:8];
                            5'd12: fb = i_start_page[7:0];
                            5'd13: fb = i_page_count[15:8];
                            5'd14: fb = i_page_count[7:0];
                            5'd15: fb = search_sum[15:8];
                            default: begin
                                fb    = search_sum[7:0];
                                flast = 1'b1;
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= 5'd0;
        end else begin
            if (advance) begin
                r_valid <= r_busy;
            end
            if (!r_busy) begin
                if (i_req_valid) begin
                    r_busy <= 1'b1;
                    r_idx  <= 5'd0;
                end
            end else if (load) begin
                if (r_req.act == ACT_STATUS || flast) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req_valid) begin
            r_req <= i_req;
        end
        if (load) begin
            if (r_req.act == ACT_STATUS) begin
                r_kind   <= 1'b1;
                r_tx     <= 8'h00;
                r_last   <= 1'b0;
                r_status <= r_req.status;
                r_id     <= r_req.id;
                r_score  <= r_req.score;
            end else begin
                r_kind   <= 1'b0;
                r_tx     <= fb;
                r_last   <= flast;
                r_status <= ST_MATCH;
                r_id     <= 16'h0000;
                r_score  <= 16'h0000;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_tx_byte = r_tx;
    assign o_last    = r_last;
    assign o_status  = r_status;
    assign o_id      = r_id;
    assign o_score   = r_score;

endmodule

/* rtl/fingerprint_scan_sequencer.sv */
// Drives one capture / convert / search exchange with a UART fingerprint sensor. Input words
// are millisecond ticks, received bytes and start requests (selected by tuser); output words
// are command bytes to transmit (tlast on the final byte of each frame) or one final status
// word with match id and score. A word is taken every cycle as long as it produces no output;
// a word that starts a frame or a status waits in the input register until the byte emitter
// is free. A frame of 12, 13 or 17 bytes leaves back to back while the sink is ready; its first
// byte passes through the input register, the emitter request register and the emitter output
// register. Configuration writes are only legal while no scan output is pending.
module fingerprint_scan_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // tx_byte, scan_status, match_id, match_score, pad
    output logic        o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast,   // last_byte
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import fss_pkg::*;

    logic [15:0]      r_cap_to;
    logic [15:0]      r_predelay;
    logic [15:0]      r_conv_to;
    logic [15:0]      r_search_to;
    logic [15:0]      r_start_pg;
    logic [15:0]      r_page_cnt;
    logic [31:0]      r_addr;

    logic             r_in_valid;
    logic [1:0]       r_in_op;
    logic [7:0]       r_in_byte;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [15:0]      r_elapsed;
    logic [15:0]      n_elapsed;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_head [HEAD_KEEP];
    logic [7:0]       hv     [HEAD_KEEP];

    logic             in_wait;
    logic             is_byte;
    logic             store;
    logic [7:0]       code;
    logic [16:0]      expect_len;
    logic [15:0]      elapsed_inc;
    logic [15:0]      limit;
    t_act_req         dec;
    logic             go_predelay;
    logic             emit_ready;
    logic             proc_go;
    logic             out_kind;
    logic [7:0]       out_tx;
    logic             out_last;
    logic [1:0]       out_status;
    logic [15:0]      out_id;
    logic [15:0]      out_score;

    assign in_wait = r_phase == PH_WAIT_CAPTURE || r_phase == PH_WAIT_CONVERT
                  || r_phase == PH_WAIT_SEARCH;
    assign is_byte = r_in_op == OP_BYTE;
    assign store   = is_byte && in_wait && r_count < CNT_W'(REPLY_BUFFER_BYTES);
    assign n_count = store ? r_count + CNT_W'(1) : r_count;

    always_comb begin
        for (int i = 0; i < HEAD_KEEP; i++) begin
            hv[i] = (store && r_count == CNT_W'(i)) ? r_in_byte : r_head[i];
        end
    end

    always_comb begin
        if (n_count >= CNT_W'(ACK_MIN_BYTES) && hv[0] == SOF_HI && hv[1] == SOF_LO
            && hv[6] == PID_ACK) begin
            code = hv[9];
        end else begin
            code = CC_NOACK;
        end
    end

    assign expect_len  = 17'd9 + {1'b0, hv[7], hv[8]};
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;

    always_comb begin
        unique case (r_phase)
            PH_WAIT_CAPTURE: limit = r_cap_to;
            PH_WAIT_CONVERT: limit = r_conv_to;
            default:         limit = r_search_to;
        endcase
    end

    // decision for the word held in the input register
    always_comb begin
        dec         = '{act: ACT_NONE, status: ST_MATCH, id: 16'h0000, score: 16'h0000};
        go_predelay = 1'b0;
        unique case (r_in_op)
            OP_START: dec.act = ACT_CAPTURE;
            OP_BYTE: begin
                if (in_wait && code != CC_NOACK) begin
                    unique case (r_phase)
                        PH_WAIT_CAPTURE: begin
                            if (code == CC_OK) begin
                                if (r_predelay == 16'h0000) begin
                                    dec.act = ACT_CONVERT;
                                end else begin
                                    go_predelay = 1'b1;
                                end
                            end else begin
                                dec.act    = ACT_STATUS;
                                dec.status = (code == CC_NOFING) ? ST_NOMATCH : ST_ERROR;
                            end
                        end
                        PH_WAIT_CONVERT: begin
                            if (code == CC_OK) begin
                                dec.act = ACT_SEARCH;
                            end else begin
                                dec.act    = ACT_STATUS;
                                dec.status = ST_ERROR;
                            end
                        end
                        default: begin
                            if (code != CC_OK) begin
                                dec.act    = ACT_STATUS;
                                dec.status = ST_NOMATCH;
                            end else if ({{(17-CNT_W){1'b0}}, n_count} >= expect_len
                                         && n_count >= CNT_W'(HEAD_KEEP)) begin
                                dec.act    = ACT_STATUS;
                                dec.status = ST_MATCH;
                                dec.id     = {hv[10], hv[11]};
                                dec.score  = {hv[12], hv[13]};
                            end
                        end
                    endcase
                end
            end
            OP_TICK: begin
                if (r_phase == PH_PREDELAY) begin
                    if (elapsed_inc >= r_predelay) begin
                        dec.act = ACT_CONVERT;
                    end
                end else if (in_wait && r_elapsed >= limit) begin
                    dec.act    = ACT_STATUS;
                    dec.status = (r_phase == PH_WAIT_CONVERT) ? ST_ERROR : ST_NOMATCH;
                end
            end
            default: dec.act = ACT_NONE;
        endcase
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        unique case (dec.act)
            ACT_CAPTURE: begin
                n_phase   = PH_WAIT_CAPTURE;
                n_elapsed = 16'h0000;
            end
            ACT_CONVERT: begin
                n_phase   = PH_WAIT_CONVERT;
                n_elapsed = 16'h0000;
            end
            ACT_SEARCH: begin
                n_phase   = PH_WAIT_SEARCH;
                n_elapsed = 16'h0000;
            end
            ACT_STATUS: begin
                n_phase   = PH_IDLE;
                n_elapsed = 16'h0000;
            end
            default: begin
                if (go_predelay) begin
                    n_phase   = PH_PREDELAY;
                    n_elapsed = 16'h0000;
                end else if (r_in_op == OP_TICK) begin
                    if (r_phase == PH_PREDELAY) begin
                        n_elapsed = elapsed_inc;
                    end else if (in_wait) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
            end
        endcase
    end

    assign proc_go         = r_in_valid && (dec.act == ACT_NONE || emit_ready);
    assign o_s_axis_tready = !r_in_valid || proc_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_to    <= 16'd200;
            r_predelay  <= 16'd10;
            r_conv_to   <= 16'd400;
            r_search_to <= 16'd200;
            r_start_pg  <= 16'd0;
            r_page_cnt  <= 16'd163;
            r_addr      <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAP_TO:    r_cap_to    <= i_cfg_data[15:0];
                REG_PREDELAY:  r_predelay  <= i_cfg_data[15:0];
                REG_CONV_TO:   r_conv_to   <= i_cfg_data[15:0];
                REG_SEARCH_TO: r_search_to <= i_cfg_data[15:0];
                REG_START_PG:  r_start_pg  <= i_cfg_data[15:0];
                REG_PAGE_CNT:  r_page_cnt  <= i_cfg_data[15:0];
                REG_ADDR:      r_addr      <= i_cfg_data;
                default:       r_addr      <= r_addr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_elapsed  <= 16'h0000;
            r_count    <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (proc_go) begin
                r_phase   <= n_phase;
                r_elapsed <= n_elapsed;
                r_count   <= (dec.act != ACT_NONE) ? '0 : n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_op   <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
        if (proc_go && store) begin
            for (int i = 0; i < HEAD_KEEP; i++) begin
                r_head[i] <= hv[i];
            end
        end
    end

    fss_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (r_in_valid && dec.act != ACT_NONE),
        .i_req        (dec),
        .o_req_ready  (emit_ready),
        .i_dev_addr   (r_addr),
        .i_start_page (r_start_pg),
        .i_page_count (r_page_cnt),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_kind       (out_kind),
        .o_tx_byte    (out_tx),
        .o_last       (out_last),
        .o_status     (out_status),
        .o_id         (out_id),
        .o_score      (out_score)
    );

    assign o_m_axis_tdata = {6'b000000, out_score, out_id, out_status, out_tx};
    assign o_m_axis_tuser = out_kind;
    assign o_m_axis_tlast = out_last;

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    localparam int LIMIT_CYCLES   = 500000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int REPLY_OVERHEAD = 9;
    localparam int PHASE_WORDS    = 84;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] CC_BADIMG = 8'h03;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] score;
    } t_out_word;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        bit         typed;
        logic [1:0] st;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // rx_byte
    logic [1:0]  i_s_axis_tuser;   // opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;   // tx_byte, scan_status, match_id, match_score, pad
    logic        o_m_axis_tuser;   // kind
    logic        o_m_axis_tlast;   // last_byte
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    fingerprint_scan_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // sequencer shadow: settings and scan state
    logic [15:0] cap_to, predelay, conv_to, search_to, start_pg, page_cnt;
    logic [31:0] dev_addr;
    t_phase      ph;
    logic [15:0] elapsed;
    int          rx_count;
    logic [7:0]  rx_head [HEAD_KEEP];

    t_out_word step_words[$];
    t_out_word due_words[$];

    int src_idle_pct;
    int sink_stall_pct;
    int n_cycles = 0;
    int n_errors;
    int n_words;
    int n_effective;
    int n_out;
    int n_frames;
    int n_status [3];

    t_dir_row dir_rows [18] = '{
        '{OP_TICK,   8'h00,     1'b0, ST_MATCH},   // idle tick
        '{OP_BYTE,   8'hFF,     1'b0, ST_MATCH},   // stray byte
        '{OP_UNUSED, 8'h5A,     1'b0, ST_MATCH},
        '{OP_START,  8'h00,     1'b0, ST_MATCH},
        '{OP_START,  8'hFF,     1'b0, ST_MATCH},   // restart during capture
        '{OP_BYTE,   SOF_HI,    1'b0, ST_MATCH},
        '{OP_BYTE,   SOF_LO,    1'b0, ST_MATCH},
        '{OP_BYTE,   8'hFF,     1'b0, ST_MATCH},
        '{OP_BYTE,   8'hFF,     1'b0, ST_MATCH},
        '{OP_BYTE,   8'hFF,     1'b0, ST_MATCH},
        '{OP_BYTE,   8'hFF,     1'b0, ST_MATCH},
        '{OP_BYTE,   PID_ACK,   1'b0, ST_MATCH},
        '{OP_BYTE,   8'h00,     1'b0, ST_MATCH},
        '{OP_BYTE,   8'h03,     1'b0, ST_MATCH},
        '{OP_BYTE,   CC_BADIMG, 1'b0, ST_MATCH},
        '{OP_BYTE,   8'h00,     1'b0, ST_MATCH},
        '{OP_BYTE,   8'h0D,     1'b1, ST_ERROR},   // bad capture code ends in error
        '{OP_START,  8'hA5,     1'b0, ST_MATCH}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("** fingerprint_scan_sequencer: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);

    function automatic void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_CAP_TO:    cap_to    = val[15:0];
            REG_PREDELAY:  predelay  = val[15:0];
            REG_CONV_TO:   conv_to   = val[15:0];
            REG_SEARCH_TO: search_to = val[15:0];
            REG_START_PG:  start_pg  = val[15:0];
            REG_PAGE_CNT:  page_cnt  = val[15:0];
            REG_ADDR:      dev_addr  = val;
            default: ;
        endcase
    endfunction

    // command frame: header, address, type, length, payload, 16-bit sum
    function automatic void queue_frame(logic [47:0] pl, int plen);
        logic [7:0]  fr [17];
        logic [15:0] len;
        logic [15:0] sum;
        int          n;
        t_out_word   w;
        len = 16'(plen + 2);
        sum = 16'(PID_CMD) + len[15:8] + len[7:0];
        fr[0] = SOF_HI;
        fr[1] = SOF_LO;
        fr[2] = dev_addr[31:24];
        fr[3] = dev_addr[23:16];
        fr[4] = dev_addr[15:8];
        fr[5] = dev_addr[7:0];
        fr[6] = PID_CMD;
        fr[7] = len[15:8];
        fr[8] = len[7:0];
        n = 9;
        for (int i = 0; i < plen; i++) begin
            fr[n] = pl[8*i +: 8];
            sum = sum + pl[8*i +: 8];
            n++;
        end
        fr[n] = sum[15:8];
        fr[n+1] = sum[7:0];
        n = n + 2;
        for (int i = 0; i < n; i++) begin
            w = '0;
            w.tx = fr[i];
            w.last = (i == n - 1);
            step_words.push_back(w);
        end
        elapsed = '0;
        rx_count = 0;
    endfunction

    function automatic void close_scan(logic [1:0] st, logic [15:0] id, logic [15:0] score);
        t_out_word w;
        w = '0;
        w.kind = 1'b1;
        w.status = st;
        w.id = id;
        w.score = score;
        step_words.push_back(w);
        ph = PH_IDLE;
        elapsed = '0;
        rx_count = 0;
    endfunction

    function automatic void send_convert();
        ph = PH_WAIT_CONVERT;
        queue_frame({32'h0, BUF_ID, INS_CONV}, 2);
    endfunction

    function automatic logic [7:0] confirm_code();
        if (rx_count < ACK_MIN_BYTES || rx_head[0] != SOF_HI || rx_head[1] != SOF_LO ||
            rx_head[6] != PID_ACK)
            return CC_NOACK;
        return rx_head[9];
    endfunction

    function automatic bit waiting_reply();
        return ph == PH_WAIT_CAPTURE || ph == PH_WAIT_CONVERT || ph == PH_WAIT_SEARCH;
    endfunction

    // output words caused by one input word, left in step_words
    function automatic void predict_sequencer(logic [1:0] op, logic [7:0] b);
        logic [7:0]  code;
        logic [15:0] lim;
        int          need;
        step_words.delete();
        case (op)
            OP_TICK: begin
                if (ph == PH_PREDELAY) begin
                    if (elapsed != 16'hFFFF)
                        elapsed++;
                    if (elapsed >= predelay)
                        send_convert();
                end else if (waiting_reply()) begin
                    lim = (ph == PH_WAIT_CAPTURE) ? cap_to :
                          (ph == PH_WAIT_CONVERT) ? conv_to : search_to;
                    if (elapsed >= lim)
                        close_scan(ph == PH_WAIT_CONVERT ? ST_ERROR : ST_NOMATCH, '0, '0);
                    else
                        elapsed++;
                end
            end
            OP_BYTE: begin
                if (waiting_reply()) begin
                    if (rx_count < REPLY_BUFFER_BYTES) begin
                        if (rx_count < HEAD_KEEP)
                            rx_head[rx_count] = b;
                        rx_count++;
                    end
                    code = confirm_code();
                    if (code != CC_NOACK) begin
                        case (ph)
                            PH_WAIT_CAPTURE: begin
                                if (code != CC_OK) begin
                                    close_scan(code == CC_NOFING ? ST_NOMATCH : ST_ERROR, '0, '0);
                                end else if (predelay == 0) begin
                                    send_convert();
                                end else begin
                                    ph = PH_PREDELAY;
                                    elapsed = '0;
                                end
                            end
                            PH_WAIT_CONVERT: begin
                                if (code == CC_OK) begin
                                    ph = PH_WAIT_SEARCH;
                                    queue_frame({page_cnt[7:0], page_cnt[15:8], start_pg[7:0],
                                                 start_pg[15:8], BUF_ID, INS_SEARCH}, 6);
                                end else begin
                                    close_scan(ST_ERROR, '0, '0);
                                end
                            end
                            default: begin
                                need = REPLY_OVERHEAD + int'({rx_head[7], rx_head[8]});
                                if (code != CC_OK)
                                    close_scan(ST_NOMATCH, '0, '0);
                                else if (rx_count >= need && rx_count >= HEAD_KEEP)
                                    close_scan(ST_MATCH, {rx_head[10], rx_head[11]},
                                               {rx_head[12], rx_head[13]});
                            end
                        endcase
                    end
                end
            end
            OP_START: begin
                ph = PH_WAIT_CAPTURE;
                queue_frame({40'h0, INS_CAP}, 1);
            end
            default: ;
        endcase
    endfunction

    task automatic push_word(logic [1:0] op, logic [7:0] b, bit typed = 1'b0,
                             logic [1:0] typed_st = ST_MATCH);
        t_out_word w;
        while ($urandom_range(99, 0) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (op == OP_START || (op == OP_TICK && ph != PH_IDLE) ||
            (op == OP_BYTE && waiting_reply()))
            n_effective++;
        n_words++;
        predict_sequencer(op, b);
        if (typed) begin
            w = '0;
            w.kind = 1'b1;
            w.status = typed_st;
            due_words.push_back(w);
        end else begin
            foreach (step_words[i])
                due_words.push_back(step_words[i]);
        end
    endtask

    // sensor reply: header, address, ack type, length, confirm code, random rest
    task automatic send_reply(logic [7:0] code, logic [15:0] plen, int n_send);
        logic [7:0] rb [72];
        int         k;
        foreach (rb[i])
            rb[i] = 8'($urandom);
        rb[0] = SOF_HI;
        rb[1] = SOF_LO;
        rb[6] = PID_ACK;
        rb[7] = plen[15:8];
        rb[8] = plen[7:0];
        rb[9] = code;
        if ($urandom_range(99, 0) < 8) begin
            k = $urandom_range(2, 0);
            k = (k == 2) ? 6 : k;
            rb[k] = rb[k] ^ 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < n_send; i++)
            push_word(OP_BYTE, rb[i]);
    endtask

    task automatic run_random(int quota);
        int          stop;
        int          r;
        int          k;
        int          n_send;
        logic [7:0]  code;
        logic [15:0] plen;
        stop = n_effective + quota;
        while (n_effective < stop) begin
            r = $urandom_range(99, 0);
            case (ph)
                PH_IDLE: begin
                    if (r < 80)
                        push_word(OP_START, 8'($urandom));
                    else if (r < 90)
                        push_word(OP_TICK, 8'($urandom));
                    else if (r < 97)
                        push_word(OP_BYTE, 8'($urandom));
                    else
                        push_word(OP_UNUSED, 8'($urandom));
                end
                PH_PREDELAY: begin
                    if (r < 85)
                        repeat ($urandom_range(4, 1)) push_word(OP_TICK, 8'($urandom));
                    else if (r < 92)
                        push_word(OP_START, 8'($urandom));
                    else
                        push_word(OP_BYTE, 8'($urandom));
                end
                default: begin
                    if (r < 65) begin
                        k = $urandom_range(99, 0);
                        plen = 16'd3;
                        case (ph)
                            PH_WAIT_CAPTURE:
                                code = (k < 60) ? CC_OK : (k < 75) ? CC_NOFING :
                                       (k < 90) ? 8'($urandom) : CC_NOACK;
                            PH_WAIT_CONVERT:
                                code = (k < 75) ? CC_OK : (k < 90) ? 8'($urandom) : CC_NOACK;
                            default: begin
                                code = (k < 70) ? CC_OK : (k < 88) ? 8'($urandom) : CC_NOACK;
                                k = $urandom_range(99, 0);
                                plen = (k < 70) ? 16'd7 : (k < 85) ? 16'($urandom_range(4, 0)) :
                                       16'($urandom_range(60, 8));
                            end
                        endcase
                        n_send = REPLY_OVERHEAD + int'(plen);
                        if (ph == PH_WAIT_SEARCH && n_send < HEAD_KEEP)
                            n_send = HEAD_KEEP;
                        if (r >= 55)
                            n_send = $urandom_range(ACK_MIN_BYTES - 1, 1);
                        send_reply(code, plen, n_send);
                    end else if (r < 80) begin
                        repeat ($urandom_range(6, 1)) push_word(OP_TICK, 8'($urandom));
                    end else if (r < 87) begin
                        repeat ($urandom_range(4, 1)) push_word(OP_BYTE, 8'($urandom));
                    end else if (r < 95) begin
                        push_word(OP_START, 8'($urandom));
                    end else begin
                        push_word(OP_UNUSED, 8'($urandom));
                    end
                end
            endcase
        end
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        set_reg(idx, val);
    endtask

    task automatic program_regs(logic [31:0] cap, logic [31:0] pre, logic [31:0] conv,
                                logic [31:0] srch, logic [31:0] first_pg, logic [31:0] cnt,
                                logic [31:0] addr);
        write_reg(REG_CAP_TO, cap);
        write_reg(REG_PREDELAY, pre);
        write_reg(REG_CONV_TO, conv);
        write_reg(REG_SEARCH_TO, srch);
        write_reg(REG_START_PG, first_pg);
        write_reg(REG_PAGE_CNT, cnt);
        write_reg(REG_ADDR, addr);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : out_check
        t_out_word w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_out++;
            if (due_words.size() == 0) begin
                $error("unexpected output word: kind %0d tdata %h", o_m_axis_tuser,
                       o_m_axis_tdata);
                n_errors++;
            end else begin
                w = due_words.pop_front();
                check_field("kind", 16'(w.kind), 16'(o_m_axis_tuser));
                check_field("tx_byte", 16'(w.tx), 16'(o_m_axis_tdata[7:0]));
                check_field("last_byte", 16'(w.last), 16'(o_m_axis_tlast));
                check_field("scan_status", 16'(w.status), 16'(o_m_axis_tdata[9:8]));
                check_field("match_id", w.id, o_m_axis_tdata[25:10]);
                check_field("match_score", w.score, o_m_axis_tdata[41:26]);
                if (w.kind)
                    n_status[w.status]++;
                else if (w.last)
                    n_frames++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        n_errors = 0;
        n_words = 0;
        n_effective = 0;
        n_out = 0;
        n_frames = 0;
        n_status = '{0, 0, 0};
        cap_to = 16'd200;
        predelay = 16'd10;
        conv_to = 16'd400;
        search_to = 16'd200;
        start_pg = 16'd0;
        page_cnt = 16'd163;
        dev_addr = 32'hFFFF_FFFF;
        ph = PH_IDLE;
        elapsed = '0;
        rx_count = 0;
        foreach (rx_head[i])
            rx_head[i] = '0;
        src_idle_pct = 28;
        sink_stall_pct = 67;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            push_word(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].st);
        run_random(PHASE_WORDS);
        settle();

        // short timeouts and delays, random pages and address
        program_regs($urandom_range(8, 0), $urandom_range(4, 0), $urandom_range(8, 0),
                     $urandom_range(10, 0), $urandom, $urandom, $urandom);
        run_random(PHASE_WORDS);
        settle();

        src_idle_pct = 67;
        sink_stall_pct = 28;
        program_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, $urandom);
        run_random(PHASE_WORDS);
        settle();

        src_idle_pct = 0;
        sink_stall_pct = 0;
        program_regs('0, '0, '0, '0, '0, '0, '0);
        run_random(PHASE_WORDS);
        settle();

        $display("run: %0d input words (%0d acted on), %0d output words in %0d frames",
                 n_words, n_effective, n_out, n_frames);
        $display("scan outcomes: match %0d, no match %0d, error %0d; four register settings",
                 n_status[0], n_status[1], n_status[2]);
        if (n_errors == 0)
            $display("** fingerprint_scan_sequencer: PASSED **");
        else
            $display("** fingerprint_scan_sequencer: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/fss_pkg.sv
rtl/fss_emit.sv
rtl/fingerprint_scan_sequencer.sv
tb/tb.sv
